// ===== hdl/bldc_pkg.sv =====
`default_nettype none

package bldc_pkg;

  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned ADC_W       = 12;
  localparam int unsigned DUTY_W      = 11;
  localparam int unsigned SECTOR_W    = 3;
  localparam int unsigned KP_W        = 16;
  localparam int unsigned PERIOD_W    = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // current average length, a power of two
  localparam int unsigned CUR_AVG_LOG2 = 4;
  localparam int unsigned CUR_AVG_LEN  = 1 << CUR_AVG_LOG2;
  localparam int unsigned CUR_SUM_W    = ADC_W + CUR_AVG_LOG2;

  // electrical period in angle units and its reciprocal for the quotient estimate
  localparam int unsigned ELEC_PERIOD  = 5143;
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam int unsigned RECIP_MULT   = (1 << RECIP_SHIFT) / ELEC_PERIOD;
  localparam int unsigned QUOT_W       = 4;
  localparam int unsigned POS_W        = 14;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 11'd1024;

  localparam logic [0:0] REG_KP_GAIN     = 1'b0;
  localparam logic [0:0] REG_SLOW_PERIOD = 1'b1;

  localparam logic [KP_W-1:0]     KP_RESET     = 16'd57042;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd32;

  typedef struct packed {
    logic [2:0][DUTY_W-1:0] duty;
    logic [2:0]             en;
  } phase_drive_t;

  // pwm phase gets the duty, ground phase is enabled at duty 0, the third floats
  function automatic phase_drive_t drive_for_sector(input logic [SECTOR_W-1:0] sec,
                                                    input logic [DUTY_W-1:0]   duty);
    phase_drive_t pd;
    pd = '0;
    case (sec)
      3'd0: begin pd.duty[0] = duty; pd.en = 3'b101; end
      3'd1: begin pd.duty[1] = duty; pd.en = 3'b110; end
      3'd2: begin pd.duty[1] = duty; pd.en = 3'b011; end
      3'd3: begin pd.duty[2] = duty; pd.en = 3'b101; end
      3'd4: begin pd.duty[2] = duty; pd.en = 3'b110; end
      3'd5: begin pd.duty[0] = duty; pd.en = 3'b011; end
      default: pd = '0;
    endcase
    return pd;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bldc_six_step_commutation.sv =====
`default_nettype none

// channel | direction | tdata fields (lsb first)
// in      | slave     | rotor_angle[15:0] button_pressed[16] pot_sample[28:17]
//         |           | current_sample[40:29]
// out     | master    | duty_a[10:0] duty_b[21:11] duty_c[32:22] enable_a..c[35:33]
//         |           | driver_enable[36] sector[39:37]
// cfg     | write     | index 0 kp_gain, index 1 slow_period
//
// one transaction per clock sustained while out_tready is high; input goes through
// an input register (holding the angle quotient estimate) and the result register.
// all state updates happen in the single pass between those two registers.
// a held result does not block intake while the input register is empty.
// rst_n is synchronous and active low; config takes effect on the next transaction.

module bldc_six_step_commutation
  import bldc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // rotor_angle, button_pressed, pot_sample, current_sample
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // duty_a, duty_b, duty_c, enable_a, enable_b, enable_c, driver_enable, sector
  output logic [OUT_TDATA_W-1:0]      out_tdata,

  input  wire logic                   cfg_wr_en,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // config
  logic [KP_W-1:0]     kp_gain_r;
  logic [PERIOD_W-1:0] slow_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r     <= KP_RESET;
      slow_period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KP_GAIN:     kp_gain_r     <= cfg_wdata;
        REG_SLOW_PERIOD: slow_period_r <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  s1_valid_r;
  logic [ANGLE_W-1:0]    s1_angle_r;
  logic                  s1_button_r;
  logic [ADC_W-1:0]      s1_pot_r;
  logic [ADC_W-1:0]      s1_cur_r;
  logic [QUOT_W-1:0]     s1_quot_r;

  logic                  advance;
  logic                  in_accept;
  logic [ANGLE_W+RECIP_SHIFT-1:0] quot_prod;

  assign advance   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;
  assign quot_prod = (ANGLE_W+RECIP_SHIFT)'(in_tdata[ANGLE_W-1:0])
                   * (ANGLE_W+RECIP_SHIFT)'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_angle_r  <= in_tdata[15:0];
      s1_button_r <= in_tdata[16];
      s1_pot_r    <= in_tdata[28:17];
      s1_cur_r    <= in_tdata[40:29];
      s1_quot_r   <= quot_prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // state
  logic [PERIOD_W-1:0]     tick_r,        tick_nxt;
  logic [ADC_W:0]          pot_sum_r,     pot_sum_nxt;
  logic                    pot_phase_r,   pot_phase_nxt;
  logic [ADC_W-1:0]        pot_value_r,   pot_value_nxt;
  logic [CUR_SUM_W-1:0]    cur_sum_r,     cur_sum_nxt;
  logic [CUR_AVG_LOG2-1:0] cur_cnt_r,     cur_cnt_nxt;
  logic [ADC_W-1:0]        cur_avg_r,     cur_avg_nxt;
  logic [DUTY_W-1:0]       duty_r,        duty_nxt;
  logic                    running_r,     running_nxt;
  logic                    btn_latch_r,   btn_latch_nxt;
  logic [SECTOR_W-1:0]     sector_r,      sector_nxt;
  phase_drive_t            drive_r,       drive_nxt;

  // single pass logic
  logic                    slow;
  logic signed [ADC_W:0]   err;
  logic signed [29:0]      prod;
  logic [13:0]             prod_hi;
  logic [ADC_W:0]          pot_acc;
  logic [CUR_SUM_W-1:0]    cur_acc;
  logic [ANGLE_W-1:0]      rem_raw;
  logic [POS_W-1:0]        pos;

  assign slow    = tick_r >= slow_period_r;
  assign err     = $signed({3'b000, pot_value_r[ADC_W-1:2]}) - $signed({1'b0, cur_avg_r});
  assign prod    = 30'(err) * $signed({14'd0, kp_gain_r});
  assign prod_hi = prod[29:16];
  assign pot_acc = pot_sum_r + (ADC_W+1)'(s1_pot_r);
  assign cur_acc = cur_sum_r + CUR_SUM_W'(s1_cur_r);
  assign rem_raw = s1_angle_r - ANGLE_W'(s1_quot_r) * ANGLE_W'(ELEC_PERIOD);
  assign pos     = (rem_raw >= ANGLE_W'(ELEC_PERIOD))
                 ? POS_W'(rem_raw - ANGLE_W'(ELEC_PERIOD)) : POS_W'(rem_raw);

  always_comb begin
    tick_nxt      = tick_r + 8'd1;
    duty_nxt      = duty_r;
    btn_latch_nxt = btn_latch_r;
    running_nxt   = running_r;
    pot_sum_nxt   = pot_sum_r;
    pot_phase_nxt = pot_phase_r;
    pot_value_nxt = pot_value_r;
    sector_nxt    = sector_r;
    drive_nxt     = drive_r;

    if (slow) begin
      tick_nxt = '0;
      if (running_r) begin
        if (prod[29]) begin
          duty_nxt = '0;
        end else if (prod_hi > 14'(DUTY_FULL)) begin
          duty_nxt = DUTY_FULL;
        end else begin
          duty_nxt = prod_hi[DUTY_W-1:0];
        end
      end
      if (s1_button_r) begin
        btn_latch_nxt = 1'b1;
      end else if (btn_latch_r) begin
        btn_latch_nxt = 1'b0;
        running_nxt   = !running_r;
      end
      if (pot_phase_r) begin
        pot_value_nxt = pot_acc[ADC_W:1];
        pot_sum_nxt   = '0;
        pot_phase_nxt = 1'b0;
      end else begin
        pot_sum_nxt   = pot_acc;
        pot_phase_nxt = 1'b1;
      end
    end

    if (running_nxt) begin
      if (pos <= 14'd600 || pos > 14'd5050) begin
        sector_nxt = 3'd3;
      end else if (pos <= 14'd1647) begin
        sector_nxt = 3'd4;
      end else if (pos <= 14'd2498) begin
        sector_nxt = 3'd5;
      end else if (pos <= 14'd3300) begin
        sector_nxt = 3'd0;
      end else if (pos <= 14'd4100) begin
        sector_nxt = 3'd1;
      end else if (pos < 14'd5050) begin
        sector_nxt = 3'd2;
      end
      drive_nxt = drive_for_sector(sector_nxt, duty_nxt);
    end

    if (cur_cnt_r == CUR_AVG_LOG2'(CUR_AVG_LEN - 1)) begin
      cur_cnt_nxt = '0;
      cur_avg_nxt = cur_acc[CUR_SUM_W-1 -: ADC_W];
      cur_sum_nxt = '0;
    end else begin
      cur_cnt_nxt = cur_cnt_r + CUR_AVG_LOG2'(1);
      cur_avg_nxt = cur_avg_r;
      cur_sum_nxt = cur_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      pot_sum_r   <= '0;
      pot_phase_r <= 1'b0;
      pot_value_r <= '0;
      cur_sum_r   <= '0;
      cur_cnt_r   <= '0;
      cur_avg_r   <= '0;
      duty_r      <= '0;
      running_r   <= 1'b1;
      btn_latch_r <= 1'b0;
      sector_r    <= '0;
      drive_r     <= '0;
    end else if (advance) begin
      tick_r      <= tick_nxt;
      pot_sum_r   <= pot_sum_nxt;
      pot_phase_r <= pot_phase_nxt;
      pot_value_r <= pot_value_nxt;
      cur_sum_r   <= cur_sum_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      cur_avg_r   <= cur_avg_nxt;
      duty_r      <= duty_nxt;
      running_r   <= running_nxt;
      btn_latch_r <= btn_latch_nxt;
      sector_r    <= sector_nxt;
      drive_r     <= drive_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (advance) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata <= {sector_nxt, running_nxt, drive_nxt.en,
                    drive_nxt.duty[2], drive_nxt.duty[1], drive_nxt.duty[0]};
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  import bldc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int ANGLE_WRAP  = 5143;
  localparam int AVG_LEN     = 16;
  localparam int DUTY_MAX    = 1024;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               button;
    logic [ADC_W-1:0]   pot;
    logic [ADC_W-1:0]   current;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_a;
    logic [DUTY_W-1:0]   duty_b;
    logic [DUTY_W-1:0]   duty_c;
    logic                en_a;
    logic                en_b;
    logic                en_c;
    logic                drv_en;
    logic [SECTOR_W-1:0] sector;
  } drive_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [0:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bldc_six_step_commutation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // commutation predictor state
  logic [KP_W-1:0]     kp_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [7:0]          tick_cnt;
  logic [12:0]         pot_acc;
  logic                pot_half;
  logic [ADC_W-1:0]    pot_avg;
  logic [15:0]         cur_acc;
  int                  cur_cnt;
  logic [ADC_W-1:0]    cur_avg;
  logic [DUTY_W-1:0]   duty_cmd;
  logic                running;
  logic                btn_latched;
  logic [SECTOR_W-1:0] sec;
  logic [DUTY_W-1:0]   ph_duty [3];
  logic [2:0]          ph_en;
  logic                drv_on;

  drive_t expected_drive[$];
  int     mismatch_count;
  int     quiet_cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  logic   button_level;
  drive_t want;
  drive_t got;

  task automatic reset_predictor();
    kp_reg      = KP_RESET;
    period_reg  = PERIOD_RESET;
    tick_cnt    = '0;
    pot_acc     = '0;
    pot_half    = 1'b0;
    pot_avg     = '0;
    cur_acc     = '0;
    cur_cnt     = 0;
    cur_avg     = '0;
    duty_cmd    = '0;
    running     = 1'b1;
    btn_latched = 1'b0;
    sec         = '0;
    for (int i = 0; i < 3; i++) ph_duty[i] = '0;
    ph_en       = '0;
    drv_on      = 1'b1;
  endtask

  function automatic drive_t commutate_tick(input tick_t t);
    drive_t r;
    int     err;
    int     kp_val;
    longint prod;
    int     pos;
    int     pwm_ph;
    int     gnd_ph;
    if (tick_cnt >= period_reg) begin
      tick_cnt = '0;
      if (running) begin
        kp_val = kp_reg;
        err = int'(pot_avg >> 2) - int'(cur_avg);
        prod = longint'(err) * kp_val;
        if (prod < 0)
          duty_cmd = '0;
        else if ((prod >>> 16) > DUTY_MAX)
          duty_cmd = DUTY_W'(DUTY_MAX);
        else
          duty_cmd = DUTY_W'(prod >>> 16);
      end
      if (t.button) begin
        btn_latched = 1'b1;
      end else if (btn_latched) begin
        btn_latched = 1'b0;
        running = ~running;
      end
      pot_acc = pot_acc + t.pot;
      if (pot_half) begin
        pot_avg  = pot_acc[12:1];
        pot_acc  = '0;
        pot_half = 1'b0;
      end else begin
        pot_half = 1'b1;
      end
    end else begin
      tick_cnt = tick_cnt + 8'd1;
    end

    if (running) begin
      drv_on = 1'b1;
      pos = int'(t.angle) % ANGLE_WRAP;
      if (pos <= 600 || pos > 5050) sec = 3'd3;
      else if (pos <= 1647) sec = 3'd4;
      else if (pos <= 2498) sec = 3'd5;
      else if (pos <= 3300) sec = 3'd0;
      else if (pos <= 4100) sec = 3'd1;
      else if (pos < 5050) sec = 3'd2;
      // exactly 5050 keeps the previous sector
      case (sec)
        3'd0: begin pwm_ph = 0; gnd_ph = 2; end
        3'd1: begin pwm_ph = 1; gnd_ph = 2; end
        3'd2: begin pwm_ph = 1; gnd_ph = 0; end
        3'd3: begin pwm_ph = 2; gnd_ph = 0; end
        3'd4: begin pwm_ph = 2; gnd_ph = 1; end
        default: begin pwm_ph = 0; gnd_ph = 1; end
      endcase
      for (int i = 0; i < 3; i++) ph_duty[i] = '0;
      ph_en = '0;
      ph_duty[pwm_ph] = duty_cmd;
      ph_en[pwm_ph] = 1'b1;
      ph_en[gnd_ph] = 1'b1;
    end else begin
      drv_on = 1'b0;
    end

    cur_acc = cur_acc + t.current;
    cur_cnt++;
    if (cur_cnt >= AVG_LEN) begin
      cur_cnt = 0;
      cur_avg = cur_acc[15:4];
      cur_acc = '0;
    end

    r.duty_a = ph_duty[0];
    r.duty_b = ph_duty[1];
    r.duty_c = ph_duty[2];
    r.en_a   = ph_en[0];
    r.en_b   = ph_en[1];
    r.en_c   = ph_en[2];
    r.drv_en = drv_on;
    r.sector = sec;
    return r;
  endfunction

  function automatic bit drive_matches(input drive_t a, input drive_t b);
    return a.duty_a === b.duty_a && a.duty_b === b.duty_b && a.duty_c === b.duty_c &&
           a.en_a === b.en_a && a.en_b === b.en_b && a.en_c === b.en_c &&
           a.drv_en === b.drv_en && a.sector === b.sector;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.duty_a = out_tdata[10:0];
      got.duty_b = out_tdata[21:11];
      got.duty_c = out_tdata[32:22];
      got.en_a   = out_tdata[33];
      got.en_b   = out_tdata[34];
      got.en_c   = out_tdata[35];
      got.drv_en = out_tdata[36];
      got.sector = out_tdata[39:37];
      if (expected_drive.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected drive transaction %h", $time, out_tdata);
      end else begin
        want = expected_drive.pop_front();
        if (!drive_matches(want, got)) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: drive mismatch exp duty %0d/%0d/%0d en %b%b%b drv %b sec %0d, got duty %0d/%0d/%0d en %b%b%b drv %b sec %0d",
                     $time, want.duty_a, want.duty_b, want.duty_c, want.en_a, want.en_b,
                     want.en_c, want.drv_en, want.sector, got.duty_a, got.duty_b, got.duty_c,
                     got.en_a, got.en_b, got.en_c, got.drv_en, got.sector);
        end
      end
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_tick(input tick_t t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, t.current, t.pot, t.button, t.angle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_drive.push_back(commutate_tick(t));
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_gains(input int kp, input int period);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KP_GAIN;
    cfg_wdata <= CFG_DATA_W'(kp);
    @(posedge clk);
    kp_reg = KP_W'(kp);
    @(negedge clk);
    cfg_index <= REG_SLOW_PERIOD;
    cfg_wdata <= CFG_DATA_W'(period);
    @(posedge clk);
    period_reg = PERIOD_W'(period);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic tick_t make_tick(input int angle, input bit button, input int pot,
                                      input int current);
    tick_t t;
    t.angle   = ANGLE_W'(angle);
    t.button  = button;
    t.pot     = ADC_W'(pot);
    t.current = ADC_W'(current);
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    k;
    int    bounds [7];
    bounds = '{0, 600, 1647, 2498, 3300, 4100, 5050};
    k = $urandom_range(99);
    if (k < 85)
      t.angle = ANGLE_W'($urandom_range(35999));
    else if (k < 95)
      t.angle = ANGLE_W'(ANGLE_WRAP * int'($urandom_range(6)) +
                         bounds[$urandom_range(6)] + int'($urandom_range(2)) - 1);
    else
      t.angle = ANGLE_W'($urandom_range(65535));
    // button held in runs that span slow ticks, with the odd glitch
    if ($urandom_range(int'(period_reg) + 1) == 0) button_level = ~button_level;
    t.button = ($urandom_range(99) < 3) ? ~button_level : button_level;
    k = $urandom_range(9);
    t.pot = (k == 0) ? '0 : (k == 1) ? '1 : ADC_W'($urandom_range(4095));
    k = $urandom_range(9);
    t.current = (k == 0) ? '0 : (k == 1) ? '1 : ADC_W'($urandom_range(4095));
    return t;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_tick(random_tick());
  endtask

  task automatic test_sector_edges();
    int angles [17];
    angles = '{0, 600, 601, 1647, 1648, 2498, 2499, 3300, 3301, 4100, 4101, 5049,
               5050, 5051, 5142, 35999, 10193};
    for (int i = 0; i < 17; i++)
      send_tick(make_tick(angles[i], 1'b0, (i % 2) ? 4095 : 0, (i % 2) ? 0 : 4095));
  endtask

  // slow task on every tick, full gain: press and release toggles the motor
  task automatic test_start_stop();
    set_gains(65535, 0);
    send_tick(make_tick(100, 1'b0, 4095, 0));
    send_tick(make_tick(700, 1'b0, 4095, 0));
    send_tick(make_tick(1700, 1'b0, 4095, 4095));
    send_tick(make_tick(2600, 1'b1, 4095, 0));
    send_tick(make_tick(3500, 1'b0, 2048, 0));
    send_tick(make_tick(4500, 1'b0, 1024, 4095));
    send_tick(make_tick(200, 1'b1, 4095, 0));
    send_tick(make_tick(5050, 1'b0, 4095, 0));
    send_tick(make_tick(65535, 1'b0, 4095, 0));
  endtask

  task automatic test_random_steady();
    set_gains(KP_RESET, PERIOD_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_random_sender_gaps();
    set_gains(0, 1);
    send_idle_pct  = 59;
    recv_stall_pct = 0;
    run_random(380);
  endtask

  task automatic test_random_receiver_stalls();
    set_gains(65535, 255);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    run_random(190);
    settle();
    run_random(190);
  endtask

  task automatic test_random_both();
    set_gains($urandom_range(65535), $urandom_range(40, 2));
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    run_random(390);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    button_level   = 1'b0;
    reset_predictor();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_sector_edges();
    test_start_stop();
    test_random_steady();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both();

    settle();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && expected_drive.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bldc_pkg.sv
hdl/bldc_six_step_commutation.sv
tb/tb.sv
